>>> hdl/rfp_pkg.sv
package rfp_pkg;

  // default frame length in bytes, header through tail
  localparam int FRAME_LEN_DEF = 14;

  // frame marks and message id
  localparam logic [7:0] MARK_HEAD = 8'hAA;
  localparam logic [7:0] MARK_TAIL = 8'h55;
  localparam logic [7:0] ID_HIGH   = 8'h0C;
  localparam logic [7:0] ID_LOW    = 8'h07;

  // offsets that turn raw bytes into scaled units
  localparam logic [8:0]  RCS_OFS   = 9'd100;
  localparam logic [11:0] SPEED_OFS = 12'd700;
  localparam logic [8:0]  SNR_OFS   = 9'd127;

  // result word, first member in the highest bits so target_index sits at bit 0
  typedef struct packed {
    logic signed [8:0]  snr_level;
    logic signed [11:0] speed_units;
    logic        [1:0]  roll_count;
    logic signed [15:0] range_cm;
    logic signed [8:0]  rcs_half_db;
    logic        [7:0]  target_index;
  } rfp_result_t;

  localparam int RESULT_W = $bits(rfp_result_t);

endpackage

>>> hdl/rfp_decode.sv
module rfp_decode
  import rfp_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic [7:0]  frame [FRAME_LEN],
  output logic        frame_ok,
  output rfp_result_t result
);

  // header, message id and tail check
  assign frame_ok = (frame[0] == MARK_HEAD) && (frame[1] == MARK_HEAD) &&
                    (frame[2] == ID_HIGH) && (frame[3] == ID_LOW) &&
                    (frame[FRAME_LEN-2] == MARK_TAIL) &&
                    (frame[FRAME_LEN-1] == MARK_TAIL);

  // field extraction and offset removal
  always_comb begin
    result.target_index = frame[4];
    result.rcs_half_db  = $signed({1'b0, frame[5]} - RCS_OFS);
    result.range_cm     = $signed({frame[6], frame[7]});
    result.roll_count   = frame[9][7:6];
    result.speed_units  = $signed({1'b0, frame[9][2:0], frame[10]} - SPEED_OFS);
    result.snr_level    = $signed({1'b0, frame[11]} - SNR_OFS);
  end

endmodule

>>> hdl/radar_frame_parser.sv
// channel | dir | tdata fields, lowest bit up
// in_     | in  | rx_byte[7:0]
// out_    | out | target_index[7:0], rcs_half_db[16:8], range_cm[32:17],
//         |     | roll_count[34:33], speed_units[46:35], snr_level[55:47]
//
// one byte per cycle while in_tready is high; the closing byte of a good frame
// shows its result on out_ in the next cycle, set by the single output register
// rst_n (synchronous) closes any open frame and drops a pending word
// in_tready only falls when a word waits on out_ and the next byte
// could close a frame; other bytes are taken while out_ is stalled
module radar_frame_parser
  import rfp_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // rx_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // target_index, rcs_half_db, range_cm, roll_count, speed_units, snr_level
  output logic [RESULT_W-1:0] out_tdata
);

  localparam int CNT_W = $clog2(FRAME_LEN);
  localparam int IDX_W = $clog2(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_LEN - 1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [7:0]       buf_r [FRAME_LEN-1];
  logic [7:0]       frame_now [FRAME_LEN];
  logic             out_valid_r, out_valid_nxt;
  rfp_result_t      result_r, result_dec;
  logic             frame_ok;
  logic             in_acc, is_head, restart, push, close_frame, wr_en;
  logic [IDX_W-1:0] wr_idx;

  // stall input only when a closing byte could meet a waiting word
  assign in_tready = !(out_valid_r && !out_tready) || (fill_r != LAST);
  assign in_acc    = in_tvalid && in_tready;

  // byte classification against the open frame
  assign is_head     = (in_tdata == MARK_HEAD);
  assign restart     = is_head && (fill_r > CNT_W'(1));
  assign push        = !restart && (is_head || (fill_r != '0));
  assign close_frame = in_acc && push && (fill_r == LAST);
  assign wr_en       = in_acc && (restart || (push && (fill_r != LAST)));
  assign wr_idx      = restart ? '0 : fill_r[IDX_W-1:0];

  // frame as seen with the current byte in the last place
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      frame_now[i] = buf_r[i];
    end
    frame_now[FRAME_LEN-1] = in_tdata;
  end

  rfp_decode #(
    .FRAME_LEN(FRAME_LEN)
  ) u_decode (
    .frame   (frame_now),
    .frame_ok(frame_ok),
    .result  (result_dec)
  );

  // fill count next value
  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      if (restart) begin
        fill_nxt = CNT_W'(1);
      end else if (close_frame) begin
        fill_nxt = '0;
      end else if (push) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  // output word valid next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (close_frame && frame_ok) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame buffer and result payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wr_idx] <= in_tdata;
    end
    if (close_frame && frame_ok) begin
      result_r <= result_dec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

endmodule

>>> hdl/rfp_checker.sv
module rfp_checker
  import rfp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [7:0]          in_tdata,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [RESULT_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a head mark never closes a frame
  a_head_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == MARK_HEAD) &&
    !(out_tvalid && !out_tready) |=> !out_tvalid)
    else $error("head mark produced a result");

  // a new word only follows an accepted byte
  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result word without an input byte");

  // input is never held off while the output side is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && !out_tready) |-> in_tready)
    else $error("input stalled with output free");

  // reset leaves no word pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word pending after reset");

endmodule

bind radar_frame_parser rfp_checker u_rfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> tb/rfp_result_checker.sv
`timescale 1ns / 1ps

module rfp_result_checker
  import rfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [RESULT_W-1:0] out_tdata,
  output int                  fail_count,
  output int                  pending,
  output int                  good_frames,
  output int                  bad_frames,
  output int                  bytes_taken
);

  // own copy of the frame buffer and its fill level
  logic [7:0]  frame_buf [FRAME_LEN_DEF];
  int          frame_fill;
  rfp_result_t target_q [$];

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  // scale the raw frame bytes into one result word
  function automatic rfp_result_t decode_frame();
    rfp_result_t r;
    r.target_index = frame_buf[4];
    r.rcs_half_db  = {1'b0, frame_buf[5]} - RCS_OFS;
    r.range_cm     = {frame_buf[6], frame_buf[7]};
    r.roll_count   = frame_buf[9][7:6];
    r.speed_units  = {1'b0, frame_buf[9][2:0], frame_buf[10]} - SPEED_OFS;
    r.snr_level    = {1'b0, frame_buf[11]} - SNR_OFS;
    return r;
  endfunction

  // take one received byte into the frame buffer
  task automatic absorb_byte(input logic [7:0] b);
    logic frame_ok;
    if (b == MARK_HEAD) begin
      // a second mark right after the opening one is kept, any other restarts
      if (!(frame_fill == 1 && frame_buf[0] == MARK_HEAD))
        frame_fill = 0;
      frame_buf[frame_fill] = b;
      frame_fill++;
    end else if (frame_fill > 0) begin
      frame_buf[frame_fill] = b;
      frame_fill++;
    end
    // full buffer: validate marks and message id, then clear
    if (frame_fill == FRAME_LEN_DEF) begin
      frame_ok = frame_buf[0] == MARK_HEAD && frame_buf[1] == MARK_HEAD &&
                 frame_buf[FRAME_LEN_DEF-2] == MARK_TAIL &&
                 frame_buf[FRAME_LEN_DEF-1] == MARK_TAIL &&
                 frame_buf[2] == ID_HIGH && frame_buf[3] == ID_LOW;
      if (frame_ok)
        target_q = {target_q, decode_frame()};
      else
        bad_frames++;
      frame_fill = 0;
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    rfp_result_t got, want;
    if (!rst_n) begin
      frame_fill = 0;
      target_q.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = rfp_result_t'(out_tdata);
        if (target_q.size() == 0) begin
          report_error($sformatf("word with no frame behind it: target_index %0d",
                                 got.target_index));
        end else begin
          want = target_q.pop_front();
          good_frames++;
          check_field("target_index", got.target_index, want.target_index);
          check_field("rcs_half_db", got.rcs_half_db, want.rcs_half_db);
          check_field("range_cm", got.range_cm, want.range_cm);
          check_field("roll_count", got.roll_count, want.roll_count);
          check_field("speed_units", got.speed_units, want.speed_units);
          check_field("snr_level", got.snr_level, want.snr_level);
        end
      end
      if (in_tvalid && in_tready) begin
        bytes_taken++;
        absorb_byte(in_tdata);
      end
      pending = target_q.size();
    end
  end

endmodule

>>> tb/tb_radar_frame_parser.sv
`timescale 1ns / 1ps

module tb_radar_frame_parser;
  import rfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTE_TARGET = 650;
  localparam int HOLD_CYCLES = 60;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_HEAD,
    FRAME_BAD_ID,
    FRAME_BAD_TAIL,
    FRAME_CUT,
    FRAME_TRIPLE_HEAD
  } frame_kind_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // rx_byte
  logic                out_tvalid;
  logic                out_tready;
  // target_index, rcs_half_db, range_cm, roll_count, speed_units, snr_level
  logic [RESULT_W-1:0] out_tdata;

  int   fail_count, pending, good_frames, bad_frames, bytes_taken;
  int   burst_left;
  int   hold_asks, hold_served;
  int   frame_bytes_sent;
  int   cycle_count;
  logic steady;

  radar_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rfp_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .good_frames (good_frames),
    .bad_frames  (bad_frames),
    .bytes_taken (bytes_taken)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
        $display("radar_frame_parser test failed");
        $finish;
      end
    end
  end

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin : receiver
    int mode, span, hold;
    out_tready <= 1'b0;
    mode = 0;
    span = 0;
    hold = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold = HOLD_CYCLES;
        hold_served = hold_asks;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= span[1];
        endcase
      end
    end
  end

  // offer one byte and wait for it to be taken, bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 8);
    end
    if (steady)
      gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending until every expected word has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // payload byte leaning toward field extremes, never a head mark
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h7F;
      3: b = 8'h80;
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (b == MARK_HEAD)
      b = 8'hAB;
    return b;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == v || b == MARK_HEAD) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fr [FRAME_LEN_DEF];
    int n, k;
    fr[0] = MARK_HEAD;
    fr[1] = MARK_HEAD;
    fr[2] = ID_HIGH;
    fr[3] = ID_LOW;
    for (k = 4; k < FRAME_LEN_DEF - 2; k++) fr[k] = payload_byte();
    fr[FRAME_LEN_DEF-2] = MARK_TAIL;
    fr[FRAME_LEN_DEF-1] = MARK_TAIL;
    n = FRAME_LEN_DEF;
    case (kind)
      FRAME_BAD_HEAD: fr[1] = other_than(MARK_HEAD);
      FRAME_BAD_ID: begin
        k = $urandom_range(2, 3);
        fr[k] = other_than(fr[k]);
      end
      FRAME_BAD_TAIL: begin
        k = $urandom_range(FRAME_LEN_DEF - 2, FRAME_LEN_DEF - 1);
        fr[k] = other_than(MARK_TAIL);
      end
      // frame broken off, the next head mark restarts it
      FRAME_CUT: n = $urandom_range(1, FRAME_LEN_DEF - 1);
      // a third head mark in a row restarts the frame at that mark
      FRAME_TRIPLE_HEAD: begin
        send_byte(MARK_HEAD);
        frame_bytes_sent++;
      end
      default: ;
    endcase
    for (k = 0; k < n; k++) send_byte(fr[k]);
    frame_bytes_sent += n;
  endtask

  // hold the receiver off while good frames keep coming
  task automatic fill_up();
    hold_asks++;
    steady = 1'b1;
    repeat (3) send_frame(FRAME_GOOD);
    steady = 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0] directed [20];
    int i, r;
    // idle bytes, a restarted frame, then a good frame at the field extremes
    directed = '{8'h00, 8'hFF,
                 8'hAA, 8'hAA, 8'h0C, 8'h07,
                 8'hAA, 8'hAA, 8'h0C, 8'h07, 8'hFF, 8'h00, 8'h80, 8'h00,
                 8'hFF, 8'hC7, 8'hFF, 8'hFF, 8'h55, 8'h55};
    rst_n            <= 1'b0;
    in_tvalid        <= 1'b0;
    in_tdata         <= 8'h00;
    hold_asks        = 0;
    burst_left       = 0;
    frame_bytes_sent = 0;
    steady           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 20; i++) send_byte(directed[i]);
    wait_drained();
    fill_up();

    // random part: mostly well-formed frames, some broken ones and line noise
    while (frame_bytes_sent < BYTE_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(other_than(MARK_HEAD));
      end else if (r < 12) begin
        fill_up();
      end else if (r < 15) begin
        wait_drained();
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_frame(FRAME_GOOD);
          6: send_frame(FRAME_BAD_HEAD);
          7: send_frame(FRAME_BAD_ID);
          8: send_frame(FRAME_BAD_TAIL);
          default: begin
            if ($urandom_range(0, 1) != 0)
              send_frame(FRAME_CUT);
            else
              send_frame(FRAME_TRIPLE_HEAD);
          end
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d bytes taken, %0d frame words checked, %0d bad frames dropped",
             bytes_taken, good_frames, bad_frames);
    $display("%0d long output hold-offs with the input backed up", hold_asks);
    if (fail_count == 0)
      $display("radar_frame_parser test passed");
    else
      $display("radar_frame_parser test failed");
    $finish;
  end

endmodule
